[hdl/two_state_device_supervisor_unit_assert.svh]
// assertion macros used by the checker file
`ifndef TWO_STATE_DEVICE_SUPERVISOR_UNIT_ASSERT_SVH
`define TWO_STATE_DEVICE_SUPERVISOR_UNIT_ASSERT_SVH

// checked only outside reset
`define TSDS_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tsds assertion failed");

// checked at every edge, reset included
`define TSDS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("tsds assertion failed");

`endif

[hdl/tsds_pkg.sv]
package tsds_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned INDEX_W = 1;
  localparam int unsigned DATA_W  = 32;

  localparam logic [INDEX_W-1:0] REG_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    ST_READY       = 3'd0,
    ST_STARTING    = 3'd1,
    ST_RUNNING     = 3'd2,
    ST_STOPPING    = 3'd3,
    ST_FAULTED     = 3'd4,
    ST_INTERLOCKED = 3'd5
  } state_t;

  typedef enum logic [1:0] {
    FK_NONE  = 2'd0,
    FK_START = 2'd1,
    FK_STOP  = 2'd2
  } fault_t;

  typedef struct packed {
    logic              run_command;
    logic              run_feedback;
    logic              permit;
    logic              clear_fault;
    logic [TIME_W-1:0] now_ms;
  } scan_t;

  typedef struct packed {
    logic [2:0]        device_state;
    logic [1:0]        fault_kind;
    logic              alarm;
    logic [TIME_W-1:0] elapsed_ms;
  } result_t;

  typedef struct packed {
    logic              sel;
    logic              enable;
    logic              write;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } apb_req_t;

endpackage

[hdl/tsds_apb.sv]
module tsds_apb
  import tsds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  apb_req_t          req,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [TIME_W-1:0] limit
);

  logic [INDEX_W-1:0] index;

  assign index  = req.addr[ADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (req.sel && req.enable && req.write && pready && index == REG_LIMIT) begin
      limit <= req.wdata[TIME_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (index == REG_LIMIT) begin
      prdata = limit;
    end
  end

endmodule

[hdl/tsds_fsm.sv]
module tsds_fsm
  import tsds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  scan_t             scan,
  input  logic [TIME_W-1:0] limit,
  output result_t           result_next
);

  state_t            state, state_next;
  fault_t            fault_reason, fault_reason_next;
  logic [TIME_W-1:0] entry_time, entry_time_next;
  logic [TIME_W-1:0] elapsed_time, elapsed_time_next;
  logic [TIME_W-1:0] diff;
  logic              over;

  assign diff = scan.now_ms - entry_time;
  assign over = diff > limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_READY;
      fault_reason <= FK_NONE;
      entry_time   <= '0;
      elapsed_time <= '0;
    end else if (advance) begin
      state        <= state_next;
      fault_reason <= fault_reason_next;
      entry_time   <= entry_time_next;
      elapsed_time <= elapsed_time_next;
    end
  end

  always_comb begin
    state_next        = state;
    fault_reason_next = fault_reason;
    entry_time_next   = entry_time;
    elapsed_time_next = elapsed_time;
    unique case (state)
      ST_READY: begin
        if (scan.run_command && scan.permit) begin
          state_next        = ST_STARTING;
          entry_time_next   = scan.now_ms;
          elapsed_time_next = '0;
        end else if (scan.run_command) begin
          state_next = ST_INTERLOCKED;
        end
      end
      ST_STARTING: begin
        elapsed_time_next = diff;
        if (scan.run_feedback) begin
          state_next = ST_RUNNING;
        end else if (over) begin
          state_next        = ST_FAULTED;
          fault_reason_next = FK_START;
        end else if (!scan.run_command) begin
          state_next        = ST_STOPPING;
          entry_time_next   = scan.now_ms;
          elapsed_time_next = '0;
        end
      end
      ST_RUNNING: begin
        if (!scan.run_command) begin
          state_next        = ST_STOPPING;
          entry_time_next   = scan.now_ms;
          elapsed_time_next = '0;
        end else if (!scan.run_feedback) begin
          state_next        = ST_FAULTED;
          fault_reason_next = FK_STOP;
        end else if (!scan.permit) begin
          state_next = ST_INTERLOCKED;
        end
      end
      ST_STOPPING: begin
        elapsed_time_next = diff;
        if (!scan.run_feedback) begin
          state_next = ST_READY;
        end else if (over) begin
          state_next        = ST_FAULTED;
          fault_reason_next = FK_STOP;
        end
      end
      ST_FAULTED: begin
        if (scan.clear_fault) begin
          state_next        = ST_READY;
          fault_reason_next = FK_NONE;
        end
      end
      ST_INTERLOCKED: begin
        if (scan.permit) begin
          state_next = ST_READY;
        end
      end
      default: begin
        state_next = ST_READY;
      end
    endcase
  end

  assign result_next.device_state = state_next;
  assign result_next.fault_kind   = fault_reason_next;
  assign result_next.alarm        = (state_next == ST_FAULTED);
  assign result_next.elapsed_ms   = elapsed_time_next;

endmodule

[hdl/two_state_device_supervisor_unit.sv]
// Supervises a two-state device (motor and the like): each item is one scan of command,
// feedback, permit, fault clear and a wrapping millisecond timestamp, and yields one result
// with the new state, fault kind, alarm and the time spent in the current start or stop
// transition. One scan is taken every cycle while item_stall is low; each item passes through
// the input register, then the result register, with the state machine update done in the
// single combinational pass between them. The user must write the transition limit over the
// APB port at byte address 0 only while no scan is in flight; the block does not enforce it.
module two_state_device_supervisor_unit
  import tsds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              run_command,
  input  logic              run_feedback,
  input  logic              permit,
  input  logic              clear_fault,
  input  logic [TIME_W-1:0] now_ms,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [2:0]        device_state,
  output logic [1:0]        fault_kind,
  output logic              alarm,
  output logic [TIME_W-1:0] elapsed_ms,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic              scan_valid;
  scan_t             scan;
  result_t           result;
  result_t           result_next;
  logic              advance;
  logic [TIME_W-1:0] limit;
  apb_req_t          apb_req;

  assign apb_req.sel    = psel;
  assign apb_req.enable = penable;
  assign apb_req.write  = pwrite;
  assign apb_req.addr   = paddr;
  assign apb_req.wdata  = pwdata;

  tsds_apb u_apb (
    .clk    (clk),
    .rst    (rst),
    .req    (apb_req),
    .prdata (prdata),
    .pready (pready),
    .limit  (limit)
  );

  assign advance    = scan_valid && (!result_valid || !result_stall);
  assign item_stall = scan_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else if (!item_stall) begin
      scan_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      scan.run_command  <= run_command;
      scan.run_feedback <= run_feedback;
      scan.permit       <= permit;
      scan.clear_fault  <= clear_fault;
      scan.now_ms       <= now_ms;
    end
  end

  tsds_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .scan        (scan),
    .limit       (limit),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign device_state = result.device_state;
  assign fault_kind   = result.fault_kind;
  assign alarm        = result.alarm;
  assign elapsed_ms   = result.elapsed_ms;

endmodule

[hdl/tsds_checker.sv]
`include "two_state_device_supervisor_unit_assert.svh"

module tsds_checker
  import tsds_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input logic [2:0]        device_state,
  input logic [1:0]        fault_kind,
  input logic              alarm,
  input logic [TIME_W-1:0] elapsed_ms
);

  // alarm mirrors the faulted state
  `TSDS_ASSERT(a_alarm_state, clk, rst, result_valid |-> (alarm == (device_state == ST_FAULTED)))

  // a faulted device always carries a reason
  `TSDS_ASSERT(a_fault_reason, clk, rst, (result_valid && alarm) |-> (fault_kind != FK_NONE))

  // stalled result holds
  `TSDS_ASSERT(a_result_hold, clk, rst, (result_valid && result_stall) |=> (result_valid && $stable(device_state) && $stable(fault_kind) && $stable(elapsed_ms)))

  // no result straight out of reset
  `TSDS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid)

endmodule

bind two_state_device_supervisor_unit tsds_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .device_state (device_state),
  .fault_kind   (fault_kind),
  .alarm        (alarm),
  .elapsed_ms   (elapsed_ms)
);
